// ===== hdl/fcp_pkg.sv =====
// Package for the friction cone projection block: widths, beat payload types,
// the pipeline item type and the saturation and magnitude helpers. No dependencies.
package fcp_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int MU_WIDTH      = VALUE_WIDTH - 1;
    localparam int BIT_WIDTH     = $clog2(VALUE_WIDTH);
    localparam int WIDE_WIDTH    = 2 * VALUE_WIDTH + 1;
    localparam int SUM_WIDTH     = VALUE_WIDTH + 2;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef logic [VALUE_WIDTH-1:0]        t_mag;
    typedef logic [WIDE_WIDTH-1:0]         t_wide;

    typedef struct packed {
        logic [1:0]          rows;
        t_value              normal_in;
        t_value              tangent_a_in;
        t_value              tangent_b_in;
        logic [MU_WIDTH-1:0] friction_coef;
        t_value              delta_normal_in;
        t_value              delta_a_in;
        t_value              delta_b_in;
    } t_in;

    typedef struct packed {
        t_value normal_out;
        t_value tangent_a_out;
        t_value tangent_b_out;
        t_value delta_normal_out;
        t_value delta_a_out;
        t_value delta_b_out;
    } t_out;

    typedef struct packed {
        logic                has_a;
        logic                has_b;
        logic                scale;
        t_value              nrm;
        t_value              ta;
        t_value              tb;
        t_value              pn;
        t_value              dn;
        t_value              da;
        t_value              db;
        logic [MU_WIDTH-1:0] mu;
        t_mag                ma;
        t_mag                mb;
        t_mag                mn;
        t_wide               sq;
        t_wide               lim;
        t_wide               na;
        t_wide               nb;
        t_mag                root;
        t_mag                qa;
        t_mag                qb;
    } t_item;

    function automatic t_value sat(input logic signed [SUM_WIDTH-1:0] v);
        t_value r;
        if (v > SUM_WIDTH'(signed'({1'b0, {(VALUE_WIDTH-1){1'b1}}}))) begin
            r = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
        end else if (v < SUM_WIDTH'(signed'({1'b1, {(VALUE_WIDTH-1){1'b0}}}))) begin
            r = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
        end else begin
            r = v[VALUE_WIDTH-1:0];
        end
        return r;
    endfunction

    function automatic t_mag mag(input t_value v);
        t_mag r;
        if (v[VALUE_WIDTH-1]) begin
            r = t_mag'(-v);
        end else begin
            r = t_mag'(v);
        end
        return r;
    endfunction

endpackage

// ===== hdl/fcp_in_if.sv =====
// Input channel interface carrying one contact per beat.
// Depends on fcp_pkg.
interface fcp_in_if;
    logic          valid;
    logic          ready;
    fcp_pkg::t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/fcp_out_if.sv =====
// Output channel interface carrying one projected contact per beat.
// Depends on fcp_pkg.
interface fcp_out_if;
    logic          valid;
    logic          ready;
    fcp_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/friction_cone_projection.sv =====
// Top level of the friction cone projection block: front stages, square root
// chain, scale stage, divider chain and output register.
// Depends on fcp_pkg, fcp_in_if, fcp_out_if, fcp_sqrt_cell and fcp_div_cell.
//
//   channel  | dir | beat
//   i_cmd    | in  | one contact: rows, impulses, friction, accumulators
//   o_res    | out | one projected contact with updated accumulators
//
// One contact enters per cycle while no output stall has filled every stage; the
// square root chain and the divider chain each decide one bit per cell.
// Reset clears all valid flags; no clearing pass is needed.
// Empty stages close up under an output stall, so input is taken until every
// stage holds a contact.
module friction_cone_projection (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fcp_in_if.sink    i_cmd,
    fcp_out_if.source o_res
);
    localparam int W  = fcp_pkg::VALUE_WIDTH;
    localparam int NP = 2 * W + 4;
    localparam int SQ0 = 3;
    localparam int SCL = 3 + W;
    localparam int DV0 = 4 + W;

    logic           v  [NP];
    logic           en [NP];
    fcp_pkg::t_item it [NP];
    logic           r_ov;
    fcp_pkg::t_out  r_out;
    logic           en_out;

    fcp_pkg::t_item n_s0, n_s1, n_s2, n_scl;
    fcp_pkg::t_out  n_out;

    assign en_out = !r_ov || o_res.ready;
    assign en[NP-1] = !v[NP-1] || en_out;
    for (genvar k = 0; k < NP - 1; k++) begin : g_en
        assign en[k] = !v[k] || en[k+1];
    end
    assign i_cmd.ready = en[0];

    always_comb begin
        n_s0 = '0;
        n_s0.has_a = i_cmd.data.rows[1];
        n_s0.has_b = (i_cmd.data.rows == 2'd3);
        n_s0.nrm = i_cmd.data.normal_in;
        n_s0.ta = i_cmd.data.tangent_a_in;
        n_s0.tb = n_s0.has_b ? i_cmd.data.tangent_b_in : '0;
        n_s0.pn = i_cmd.data.normal_in[W-1] ? i_cmd.data.normal_in : '0;
        n_s0.dn = i_cmd.data.delta_normal_in;
        n_s0.da = i_cmd.data.delta_a_in;
        n_s0.db = i_cmd.data.delta_b_in;
        n_s0.mu = i_cmd.data.friction_coef;
        n_s0.ma = fcp_pkg::mag(n_s0.ta);
        n_s0.mb = fcp_pkg::mag(n_s0.tb);
        n_s0.mn = fcp_pkg::mag(n_s0.pn);
    end

    always_comb begin
        n_s1 = it[0];
        n_s1.sq = fcp_pkg::t_wide'(it[0].ma) * fcp_pkg::t_wide'(it[0].ma);
        n_s1.na = fcp_pkg::t_wide'(it[0].mb) * fcp_pkg::t_wide'(it[0].mb);
        n_s1.lim = fcp_pkg::t_wide'(it[0].mu) * fcp_pkg::t_wide'(it[0].mn);
    end

    always_comb begin
        n_s2 = it[1];
        n_s2.sq = it[1].sq + it[1].na;
        n_s2.lim = it[1].lim >> fcp_pkg::FRACTION_BITS;
        n_s2.root = '0;
    end

    always_comb begin
        n_scl = it[SCL-1];
        n_scl.scale = (it[SCL-1].root != '0)
                   && (it[SCL-1].lim < fcp_pkg::t_wide'(it[SCL-1].root));
        n_scl.na = fcp_pkg::t_wide'(it[SCL-1].ma)
                 * fcp_pkg::t_wide'(it[SCL-1].lim[W-1:0]);
        n_scl.nb = fcp_pkg::t_wide'(it[SCL-1].mb)
                 * fcp_pkg::t_wide'(it[SCL-1].lim[W-1:0]);
        n_scl.qa = '0;
        n_scl.qb = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            v[0] <= 1'b0;
            v[1] <= 1'b0;
            v[2] <= 1'b0;
            v[SCL] <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en[0]) begin
                v[0] <= i_cmd.valid;
            end
            if (en[1]) begin
                v[1] <= v[0];
            end
            if (en[2]) begin
                v[2] <= v[1];
            end
            if (en[SCL]) begin
                v[SCL] <= v[SCL-1];
            end
            if (en_out) begin
                r_ov <= v[NP-1];
            end
        end
        if (en[0]) begin
            it[0] <= n_s0;
        end
        if (en[1]) begin
            it[1] <= n_s1;
        end
        if (en[2]) begin
            it[2] <= n_s2;
        end
        if (en[SCL]) begin
            it[SCL] <= n_scl;
        end
        if (en_out) begin
            r_out <= n_out;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_sqrt
        fcp_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[SQ0+k]),
            .i_bit   (fcp_pkg::BIT_WIDTH'(W - 1 - k)),
            .i_valid (v[SQ0+k-1]),
            .i_item  (it[SQ0+k-1]),
            .o_valid (v[SQ0+k]),
            .o_item  (it[SQ0+k])
        );
    end

    for (genvar k = 0; k < W; k++) begin : g_div
        fcp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[DV0+k]),
            .i_bit   (fcp_pkg::BIT_WIDTH'(W - 1 - k)),
            .i_valid (v[DV0+k-1]),
            .i_item  (it[DV0+k-1]),
            .o_valid (v[DV0+k]),
            .o_item  (it[DV0+k])
        );
    end

    always_comb begin
        fcp_pkg::t_item f;
        fcp_pkg::t_value sa, sb, pa, pb;
        f = it[NP-1];
        sa = f.ta[W-1] ? -fcp_pkg::t_value'(f.qa) : fcp_pkg::t_value'(f.qa);
        sb = f.tb[W-1] ? -fcp_pkg::t_value'(f.qb) : fcp_pkg::t_value'(f.qb);
        pa = f.has_a ? (f.scale ? sa : f.ta) : '0;
        pb = f.has_b ? (f.scale ? sb : f.tb) : '0;
        n_out.normal_out = f.pn;
        n_out.tangent_a_out = pa;
        n_out.tangent_b_out = pb;
        n_out.delta_normal_out = fcp_pkg::sat(fcp_pkg::SUM_WIDTH'(f.dn)
            + fcp_pkg::SUM_WIDTH'(f.pn) - fcp_pkg::SUM_WIDTH'(f.nrm));
        n_out.delta_a_out = f.has_a ? fcp_pkg::sat(fcp_pkg::SUM_WIDTH'(f.da)
            + fcp_pkg::SUM_WIDTH'(pa) - fcp_pkg::SUM_WIDTH'(f.ta)) : '0;
        n_out.delta_b_out = f.has_b ? fcp_pkg::sat(fcp_pkg::SUM_WIDTH'(f.db)
            + fcp_pkg::SUM_WIDTH'(pb) - fcp_pkg::SUM_WIDTH'(f.tb)) : '0;
    end

    assign o_res.valid = r_ov;
    assign o_res.data = r_out;
endmodule

// ===== hdl/fcp_sqrt_cell.sv =====
// One cell of the square root chain: decides one bit of the norm.
// Depends on fcp_pkg.
module fcp_sqrt_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [fcp_pkg::BIT_WIDTH-1:0] i_bit,
    input  logic                         i_valid,
    input  fcp_pkg::t_item               i_item,
    output logic                         o_valid,
    output fcp_pkg::t_item               o_item
);
    fcp_pkg::t_wide trial;
    fcp_pkg::t_item n_item;
    logic [fcp_pkg::BIT_WIDTH:0] sh;

    always_comb begin
        sh = {1'b0, i_bit};
        trial = (fcp_pkg::t_wide'(i_item.root) << (sh + 1'b1))
              + (fcp_pkg::t_wide'(1) << (sh << 1));
        n_item = i_item;
        if (i_item.sq >= trial) begin
            n_item.sq = i_item.sq - trial;
            n_item.root = i_item.root | (fcp_pkg::t_mag'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_item <= n_item;
        end
    end
endmodule

// ===== hdl/fcp_div_cell.sv =====
// One cell of the divider chain: decides one quotient bit for both tangents.
// Depends on fcp_pkg.
module fcp_div_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic [fcp_pkg::BIT_WIDTH-1:0] i_bit,
    input  logic                         i_valid,
    input  fcp_pkg::t_item               i_item,
    output logic                         o_valid,
    output fcp_pkg::t_item               o_item
);
    fcp_pkg::t_wide dsh;
    fcp_pkg::t_item n_item;

    always_comb begin
        dsh = fcp_pkg::t_wide'(i_item.root) << i_bit;
        n_item = i_item;
        if (i_item.na >= dsh) begin
            n_item.na = i_item.na - dsh;
            n_item.qa = i_item.qa | (fcp_pkg::t_mag'(1) << i_bit);
        end
        if (i_item.nb >= dsh) begin
            n_item.nb = i_item.nb - dsh;
            n_item.qb = i_item.qb | (fcp_pkg::t_mag'(1) << i_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
        if (i_en) begin
            o_item <= n_item;
        end
    end
endmodule
